/* hdl/tile_grid_height_sampler_defines.svh */
// Assertion macros for the tile grid height sampler checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef TILE_GRID_HEIGHT_SAMPLER_DEFINES_SVH
`define TILE_GRID_HEIGHT_SAMPLER_DEFINES_SVH

// implication on the same edge, off during reset
`define TGHS_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tghs check failed");

// implication on the next edge, off during reset
`define TGHS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("tghs check failed");

// implication on the next edge, also checked across reset
`define TGHS_ASSERT_NEXT_ALWAYS(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("tghs check failed");

`endif

/* hdl/tghs_pkg.sv */
// Types, codes and helpers shared by the tile grid height sampler and its checker.
// No dependencies.
`default_nettype none
package tghs_pkg;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd1;
  localparam logic [1:0] REG_TILE_SIZE  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [15:0] TILE_SIZE_ONE = 16'd256;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_WRITE = 11'b000_0000_0100,
    ST_DIV   = 11'b000_0000_1000,
    ST_MAP   = 11'b000_0001_0000,
    ST_RD    = 11'b000_0010_0000,
    ST_MINIT = 11'b000_0100_0000,
    ST_MULA  = 11'b000_1000_0000,
    ST_RINIT = 11'b001_0000_0000,
    ST_MULR  = 11'b010_0000_0000,
    ST_DONE  = 11'b100_0000_0000
  } state_t;

  // clamp a signed tile index into 0 .. lim-1 (lim > 0)
  function automatic logic [6:0] clamp_idx(input logic signed [24:0] t, input logic [6:0] lim);
    logic [6:0] r;
    if (t < 0) r = 7'd0;
    else if (t >= $signed({18'd0, lim})) r = lim - 7'd1;
    else r = t[6:0];
    return r;
  endfunction

  function automatic logic in_grid(input logic signed [24:0] t, input logic [6:0] lim);
    return (t >= 0) && (t < $signed({18'd0, lim}));
  endfunction

endpackage
`default_nettype wire

/* hdl/tile_grid_height_sampler.sv */
// Tile grid height sampler: tile store, serial divider and shift-add interpolator.
// A write item passes through ST_WRITE and ST_DONE; a query runs a 32-step restoring divide
// of both axes in parallel, 4 store reads and two 8-step shift-add multiplies; one
// item in flight at a time. Results wait in an output register.
// Reset clears control state and then sweeps the tile store to zero, one entry a
// cycle, all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (4096 at default), no items taken.
`default_nettype none
module tile_grid_height_sampler
  import tghs_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // tile_col, tile_row, tile_level, tile_blocked, tile_water, pos_x, pos_z, 2 pad bits
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  wire logic [0:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // sampled_height, walkable, 7 pad bits
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  input  wire logic                   cfg_wr_en,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam logic [10:0] MC = 11'(MAX_COLS);
  localparam logic [10:0] MR = 11'(MAX_ROWS);

  state_t state;

  logic [6:0]  grid_width, grid_depth;
  logic [15:0] tile_size;
  logic [6:0]  w, d;
  logic [15:0] t;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd0;
      grid_depth <= 7'd0;
      tile_size  <= TILE_SIZE_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRID_WIDTH: grid_width <= cfg_data[6:0];
        REG_GRID_DEPTH: grid_depth <= cfg_data[6:0];
        REG_TILE_SIZE:  tile_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w = ({4'd0, grid_width} > MC) ? MC[6:0] : grid_width;
  assign d = ({4'd0, grid_depth} > MR) ? MR[6:0] : grid_depth;
  assign t = (tile_size == 16'd0) ? TILE_SIZE_ONE : tile_size;

  // input fields
  logic [5:0]  in_col, in_row;
  logic [15:0] in_level;
  logic        in_blk, in_wat;
  logic [23:0] in_pos [2];
  assign in_col    = s_tdata[5:0];
  assign in_row    = s_tdata[11:6];
  assign in_level  = s_tdata[27:12];
  assign in_blk    = s_tdata[28];
  assign in_wat    = s_tdata[29];
  assign in_pos[0] = s_tdata[53:30];
  assign in_pos[1] = s_tdata[77:54];

  // tile store
  logic [17:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra, clr_cnt;
  logic [17:0]   mem_wd, rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // item registers
  logic [5:0]  wr_col, wr_row;
  logic [17:0] wr_entry;
  logic        res_zero;
  logic [4:0]  cnt;

  // divider lanes: 0 is x, 1 is z
  logic        neg [2];
  logic [15:0] rem [2];
  logic [31:0] dq  [2];

  logic [6:0]  xi [2];
  logic [6:0]  zi [2];
  logic [7:0]  u, v, mshift;
  logic        inb;
  logic [1:0]  flags0;
  logic signed [15:0] hq [4];

  logic signed [25:0] acc_a, acc_b, da, db;
  logic signed [35:0] acc_r, dr;

  logic [19:0] hs;
  logic [15:0] h_sat;
  logic signed [32:0] q  [2];
  logic signed [24:0] tc [2];
  logic [16:0] dd0, dd1;
  logic [26:0] dab;
  logic [6:0]  rd_col, rd_row;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      q[i]  = neg[i] ? -$signed({1'b0, dq[i]}) : $signed({1'b0, dq[i]});
      tc[i] = q[i][32:8];
    end
    rd_col = cnt[0] ? xi[1] : xi[0];
    rd_row = cnt[1] ? zi[1] : zi[0];
    mem_ra = {RW'(rd_row), CW'(rd_col)};
    dd0 = {hq[1][15], hq[1]} - {hq[0][15], hq[0]};
    dd1 = {hq[3][15], hq[3]} - {hq[2][15], hq[2]};
    dab = {acc_b[25], acc_b} - {acc_a[25], acc_a};
    hs  = acc_r[35:16];
    if (hs[19:15] == 5'b00000 || hs[19:15] == 5'b11111) h_sat = hs[15:0];
    else h_sat = hs[19] ? 16'h8000 : 16'h7FFF;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt;
    mem_wd = 18'd0;
    if (state == ST_WRITE) begin
      mem_we = ({1'b0, wr_col} < w) && ({1'b0, wr_row} < d);
      mem_wa = {RW'(wr_row), CW'(wr_col)};
      mem_wd = wr_entry;
    end else if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {AW{1'b1}}) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0] == MODE_WRITE) state <= ST_WRITE;
            else if (w == 7'd0 || d == 7'd0) state <= ST_DONE;
            else state <= ST_DIV;
          end
        end
        ST_WRITE: state <= ST_DONE;
        ST_DIV:   if (cnt == 5'd31) state <= ST_MAP;
        ST_MAP:   state <= ST_RD;
        ST_RD:    if (cnt == 5'd4) state <= ST_MINIT;
        ST_MINIT: state <= ST_MULA;
        ST_MULA:  if (cnt == 5'd7) state <= ST_RINIT;
        ST_RINIT: state <= ST_MULR;
        ST_MULR:  if (cnt == 5'd7) state <= ST_DONE;
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt      <= 5'd0;
        wr_col   <= in_col;
        wr_row   <= in_row;
        wr_entry <= {in_wat, in_blk, in_level};
        res_zero <= (s_tuser[0] == MODE_WRITE) || (w == 7'd0) || (d == 7'd0);
        for (int i = 0; i < 2; i++) begin
          logic [23:0] mag;
          mag    = in_pos[i][23] ? 24'(-in_pos[i]) : in_pos[i];
          neg[i] <= in_pos[i][23];
          rem[i] <= 16'd0;
          dq[i]  <= {mag, 8'd0} + (in_pos[i][23] ? {16'd0, t - 16'd1} : 32'd0);
        end
      end
      ST_DIV: begin
        cnt <= cnt + 5'd1;
        for (int i = 0; i < 2; i++) begin
          logic [17:0] trial;
          trial = {1'b0, rem[i], dq[i][31]} - {2'b0, t};
          if (!trial[17]) rem[i] <= trial[15:0];
          else rem[i] <= {rem[i][14:0], dq[i][31]};
          dq[i] <= {dq[i][30:0], ~trial[17]};
        end
      end
      ST_MAP: begin
        cnt   <= 5'd0;
        xi[0] <= clamp_idx(tc[0], w);
        xi[1] <= clamp_idx(tc[0] + 25'sd1, w);
        zi[0] <= clamp_idx(tc[1], d);
        zi[1] <= clamp_idx(tc[1] + 25'sd1, d);
        u     <= q[0][7:0];
        v     <= q[1][7:0];
        inb   <= in_grid(tc[0], w) && in_grid(tc[1], d);
      end
      ST_RD: begin
        cnt <= cnt + 5'd1;
        if (cnt != 5'd0) hq[2'(cnt - 5'd1)] <= rd_data[15:0];
        if (cnt == 5'd1) flags0 <= rd_data[17:16];
      end
      ST_MINIT: begin
        cnt    <= 5'd0;
        acc_a  <= {{2{hq[0][15]}}, hq[0], 8'd0};
        acc_b  <= {{2{hq[2][15]}}, hq[2], 8'd0};
        da     <= {{9{dd0[16]}}, dd0};
        db     <= {{9{dd1[16]}}, dd1};
        mshift <= u;
      end
      ST_MULA: begin
        cnt <= cnt + 5'd1;
        if (mshift[0]) begin
          acc_a <= acc_a + da;
          acc_b <= acc_b + db;
        end
        da     <= da <<< 1;
        db     <= db <<< 1;
        mshift <= mshift >> 1;
      end
      ST_RINIT: begin
        cnt    <= 5'd0;
        acc_r  <= {{2{acc_a[25]}}, acc_a, 8'd0} + 36'sd32768;
        dr     <= {{9{dab[26]}}, dab};
        mshift <= v;
      end
      ST_MULR: begin
        cnt <= cnt + 5'd1;
        if (mshift[0]) acc_r <= acc_r + dr;
        dr     <= dr <<< 1;
        mshift <= mshift >> 1;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {7'd0,
                      !res_zero && inb && (flags0 == 2'b00),
                      res_zero ? 16'd0 : h_sat};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/tghs_checker.sv */
// Port-level checker for the tile grid height sampler, bound to the top level.
// Uses tghs_pkg and the assertion macros header.
`default_nettype none
`include "tile_grid_height_sampler_defines.svh"
module tghs_port_checker
  import tghs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // the store sweep after reset blocks input
  `TGHS_ASSERT_NEXT_ALWAYS(a_clear_after_rst, rst, !s_tready)
  // one item in flight
  `TGHS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
  // pad bits of a result are zero
  `TGHS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:17] == 7'd0)
  // a stalled result holds
  `TGHS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tile_grid_height_sampler tghs_port_checker u_tghs_checker (.*);
`default_nettype wire

/* bench/tghs_checker.sv */
// Checker for the tile grid height sampler: watches the item, result and register ports,
// predicts each result from its own copy of the tile store, and counts mismatches.
// Depends on tghs_pkg for port widths and register codes.
module tghs_checker
  import tghs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic signed [15:0] height;
    logic               walkable;
  } sample_t;

  logic [17:0] tiles [4096];
  logic [6:0]  cols_cfg;
  logic [6:0]  rows_cfg;
  logic [15:0] size_cfg;
  sample_t     expected_q[$];

  function automatic longint floor_scaled(longint p, longint t);
    if (p >= 0) return (p * 256) / t;
    return -(((-p) * 256 + t - 1) / t);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint level_of(longint c, longint r);
    return longint'($signed(tiles[r * 64 + c][15:0]));
  endfunction

  // updates the tile store on writes, returns the sample a query should give
  function automatic sample_t sample_grid(logic mode, logic [IN_TDATA_W-1:0] d);
    sample_t res;
    longint w, dp, t, px, pz, qx, qz, tx, tz, u, v, x0, x1, z0, z1, a, b, r, h;
    logic [17:0] e;
    res = '0;
    w  = cols_cfg > 64 ? 64 : cols_cfg;
    dp = rows_cfg > 64 ? 64 : rows_cfg;
    t  = size_cfg == 0 ? 256 : size_cfg;
    if (mode == MODE_WRITE) begin
      if (d[5:0] < w && d[11:6] < dp)
        tiles[d[11:6] * 64 + d[5:0]] = {d[29], d[28], d[27:12]};
      return res;
    end
    if (w == 0 || dp == 0) return res;
    px = longint'($signed(d[53:30]));
    pz = longint'($signed(d[77:54]));
    qx = floor_scaled(px, t);
    qz = floor_scaled(pz, t);
    tx = qx >>> 8;
    tz = qz >>> 8;
    u = qx - tx * 256;
    v = qz - tz * 256;
    x0 = clip(tx, 0, w - 1);
    x1 = clip(tx + 1, 0, w - 1);
    z0 = clip(tz, 0, dp - 1);
    z1 = clip(tz + 1, 0, dp - 1);
    a = level_of(x0, z0) * 256 + (level_of(x1, z0) - level_of(x0, z0)) * u;
    b = level_of(x0, z1) * 256 + (level_of(x1, z1) - level_of(x0, z1)) * u;
    r = a * 256 + (b - a) * v + 32768;
    h = clip(r >>> 16, -32768, 32767);
    res.height = h[15:0];
    if (px >= 0 && pz >= 0 && px < w * t && pz < dp * t &&
        tx >= 0 && tz >= 0 && tx < w && tz < dp) begin
      e = tiles[tz * 64 + tx];
      res.walkable = !e[16] && !e[17];
    end
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    sample_t exp_s;
    if (rst) begin
      foreach (tiles[i]) tiles[i] = '0;
      cols_cfg = 0;
      rows_cfg = 0;
      size_cfg = TILE_SIZE_ONE;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_GRID_WIDTH: cols_cfg = cfg_data[6:0];
          REG_GRID_DEPTH: rows_cfg = cfg_data[6:0];
          REG_TILE_SIZE:  size_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_q.push_back(sample_grid(s_tuser[0], s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result item with none expected: %h", m_tdata);
          errors++;
        end else begin
          exp_s = expected_q.pop_front();
          if (m_tdata[15:0] !== exp_s.height) begin
            $error("sampled_height: expected %0d, got %0d", exp_s.height,
                   $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[16] !== exp_s.walkable) begin
            $error("walkable: expected %0b, got %0b", exp_s.walkable, m_tdata[16]);
            errors++;
          end
        end
      end
    end
  end

endmodule

/* bench/tile_grid_height_sampler_tb.sv */
// Top of the tile grid height sampler bench: clock, reset, register settings and item stimulus.
// Depends on tghs_pkg, tghs_checker and the block itself.
module tile_grid_height_sampler_tb;
  import tghs_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  // index past the register list, must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   s_tvalid = 0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_wr_en = 0;
  logic [1:0]             cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     errors;
  int                     pending;
  int                     cycles = 0;
  bit                     quiet = 0;
  int                     cur_w, cur_d, cur_t;

  tile_grid_height_sampler dut (.*);
  tghs_checker chk (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) m_tready = quiet || ($urandom_range(0, 99) >= 7);

  task automatic send(logic mode, logic [5:0] col, logic [5:0] row, logic [15:0] lvl,
                      logic blk, logic wat, logic [23:0] px, logic [23:0] pz);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser  = mode;
    s_tdata  = {2'b00, pz, px, wat, blk, lvl, row, col};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  // block must be drained before registers change
  task automatic set_grid(int w, int d, int t);
    s_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_GRID_WIDTH, 16'(w));
    write_reg(REG_GRID_DEPTH, 16'(d));
    write_reg(REG_TILE_SIZE, 16'(t));
    write_reg(REG_UNUSED, 16'($urandom()));
    cur_w = w > 64 ? 64 : w;
    cur_d = d > 64 ? 64 : d;
    cur_t = t == 0 ? 256 : t;
  endtask

  // mostly near the grid, sometimes on tile edges or anywhere
  function automatic logic [23:0] pick_pos(int dim);
    longint p;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 24'($urandom());
    if (k == 1) p = longint'($urandom_range(0, dim)) * cur_t;
    else p = longint'($urandom_range(0, (dim + 4) * cur_t)) - 2 * longint'(cur_t);
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  task automatic random_write();
    logic [5:0] c, r;
    c = $urandom_range(0, 3) == 0 ? 6'($urandom()) : 6'($urandom_range(0, cur_w));
    r = $urandom_range(0, 3) == 0 ? 6'($urandom()) : 6'($urandom_range(0, cur_d));
    send(MODE_WRITE, c, r, 16'($urandom()), $urandom_range(0, 3) == 0,
         $urandom_range(0, 3) == 0, 24'($urandom()), 24'($urandom()));
  endtask

  initial begin
    int ws[8] = '{64, 127, 1, 7, 33, 64, 2, 0};
    int ds[8] = '{64, 100, 1, 5, 64, 2, 64, 0};
    int ts[8] = '{256, 0, 65535, 1, 700, 37, 128, 256};
    cur_w = 0; cur_d = 0; cur_t = 256;
    repeat (7) @(negedge clk);
    rst = 0;
    while (!s_tready) @(negedge clk);

    // empty grid after reset: all zero results
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd0, 24'd0);
    send(MODE_WRITE, 0, 0, 16'h7fff, 0, 0, 0, 0);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd128, 24'd128);

    set_grid(4, 3, 256);
    send(MODE_WRITE, 0, 0, 16'h7fff, 0, 0, 0, 0);
    send(MODE_WRITE, 3, 0, 16'h8000, 0, 0, 0, 0);
    send(MODE_WRITE, 0, 2, 16'h0100, 1, 0, 0, 0);
    send(MODE_WRITE, 3, 2, 16'hff00, 0, 1, 0, 0);
    send(MODE_WRITE, 1, 1, 16'h0280, 1, 1, 0, 0);
    send(MODE_WRITE, 4, 0, 16'h1234, 0, 0, 0, 0);   // column past grid, dropped
    send(MODE_WRITE, 0, 3, 16'h4321, 0, 0, 0, 0);   // row past grid, dropped
    send(MODE_WRITE, 63, 63, 16'h5555, 1, 1, 24'hffffff, 24'hffffff);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd0, 24'd0);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd128, 24'd0);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd640, 24'd384);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd1023, 24'd767);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd1024, 24'd0);
    send(MODE_QUERY, 0, 0, 0, 0, 0, -24'sd1, 24'd10);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'h800000, 24'h800000);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'h7fffff, 24'h7fffff);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd300, 24'd513);
    send(MODE_QUERY, 0, 0, 0, 0, 0, 24'd700, 24'd600);

    for (int ph = 0; ph < 8; ph++) begin
      set_grid(ws[ph], ds[ph], ts[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < 205; n++) begin
        if ($urandom_range(0, 99) < 35) random_write();
        else send(MODE_QUERY, 6'($urandom()), 6'($urandom()), 16'($urandom()),
                  1'($urandom()), 1'($urandom()), pick_pos(cur_w), pick_pos(cur_d));
      end
      quiet = 0;
    end

    s_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* tile_grid_height_sampler.f */
+incdir+hdl
hdl/tghs_pkg.sv
hdl/tile_grid_height_sampler.sv
hdl/tghs_checker.sv
bench/tghs_checker.sv
bench/tile_grid_height_sampler_tb.sv
